FILE: design/rpa_pkg.sv
`timescale 1ns / 1ps

package rpa_pkg;

  // Geometry of the managed page space.
  localparam int unsigned NUM_PAGES = 4096;
  localparam int unsigned PAGE_BITS = 12;
  localparam int unsigned ADDR_W    = 24;
  localparam int unsigned PIDX_W    = ADDR_W - PAGE_BITS;
  localparam int unsigned IDX_W     = $clog2(NUM_PAGES);
  localparam int unsigned CNT_W     = $clog2(NUM_PAGES + 1);
  localparam int unsigned RC_W      = 16;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned REQ_W     = 3;
  localparam int unsigned ST_W      = 3;
  localparam int unsigned WARN_W    = 2;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned PCT_SCALE = 100;
  localparam int unsigned MUL_W     = CNT_W + PCT_W;
  localparam int unsigned STEP_W    = $clog2(PCT_W);

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_ALLOC  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_FREE   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_ADDREF = 3'd2;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_INIT   = 3'd4;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_BADADDR = 3'd1;
  localparam logic [ST_W-1:0] ST_DFREE   = 3'd2;
  localparam logic [ST_W-1:0] ST_OOM     = 3'd3;
  localparam logic [ST_W-1:0] ST_UNREF   = 3'd4;
  localparam logic [ST_W-1:0] ST_SAT     = 3'd5;

  // Warning codes.
  localparam logic [WARN_W-1:0] WARN_NONE = 2'd0;
  localparam logic [WARN_W-1:0] WARN_LOW  = 2'd1;
  localparam logic [WARN_W-1:0] WARN_CRIT = 2'd2;
  localparam logic [WARN_W-1:0] WARN_OOM  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRIT  = 2'd2;

  localparam logic [RC_W-1:0] RC_MAX = '1;

  // Controller states.
  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_EXEC  = 7'b0001000,
    S_INIT  = 7'b0010000,
    S_MUL   = 7'b0100000,
    S_DIV   = 7'b1000000
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic clr_step;
    logic init_step;
    logic mul_load;
    logic div_step;
    logic out_load;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic sweep_last;
    logic div_last;
    logic out_busy;
    logic is_init;
  } sts_t;

endpackage

FILE: design/rpa_in_if.sv
`timescale 1ns / 1ps

interface rpa_in_if;
  import rpa_pkg::*;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [ADDR_W-1:0] phys_addr;

  modport source (output valid, req_type, phys_addr, input ready);
  modport sink (input valid, req_type, phys_addr, output ready);
endinterface

FILE: design/rpa_out_if.sv
`timescale 1ns / 1ps

interface rpa_out_if;
  import rpa_pkg::*;
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [ADDR_W-1:0] page_addr;
  logic [RC_W-1:0]   ref_count;
  logic [WARN_W-1:0] warning;
  logic [CNT_W-1:0]  free_pages_now;
  logic [CNT_W-1:0]  total_pages_now;
  logic [PCT_W-1:0]  pressure_percent;

  modport source (output valid, status, page_addr, ref_count, warning, free_pages_now,
                  total_pages_now, pressure_percent, input ready);
  modport sink (input valid, status, page_addr, ref_count, warning, free_pages_now,
                total_pages_now, pressure_percent, output ready);
endinterface

FILE: design/rpa_ram.sv
`timescale 1ns / 1ps

module rpa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/rpa_ctrl.sv
`timescale 1ns / 1ps

module rpa_ctrl import rpa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Clearing sweep after reset, then per request: read, execute, optional init sweep, then the percentage.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) state_d = S_READ;
      end
      S_READ: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.is_init ? S_INIT : S_MUL;
      end
      S_INIT: begin
        cmd_o.init_step = 1'b1;
        if (sts_i.sweep_last) state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_load = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_last) begin
          // Hold the last step until the result register is free.
          if (!sts_i.out_busy) begin
            cmd_o.div_step = 1'b1;
            cmd_o.out_load = 1'b1;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

endmodule

FILE: design/rpa_dp.sv
`timescale 1ns / 1ps

module rpa_dp import rpa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [REQ_W-1:0]     req_type_i,
  input  logic [ADDR_W-1:0]    phys_addr_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ST_W-1:0]      status_o,
  output logic [ADDR_W-1:0]    page_addr_o,
  output logic [RC_W-1:0]      ref_count_o,
  output logic [WARN_W-1:0]    warning_o,
  output logic [CNT_W-1:0]     free_pages_o,
  output logic [CNT_W-1:0]     total_pages_o,
  output logic [PCT_W-1:0]     pressure_o
);

  // Configuration registers.
  logic [CFG_W-1:0] first_q, low_wm_q, crit_wm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q   <= '0;
      low_wm_q  <= CFG_W'(64);
      crit_wm_q <= CFG_W'(16);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FIRST: first_q   <= cfg_data_i;
        CFG_LOW:   low_wm_q  <= cfg_data_i;
        CFG_CRIT:  crit_wm_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Captured request.
  logic [REQ_W-1:0]  req_q;
  logic [ADDR_W-1:0] addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= req_type_i;
      addr_q <= phys_addr_i;
    end
  end

  logic [PIDX_W-1:0] pidx;
  logic [IDX_W-1:0]  ridx;
  logic              in_range, aligned, above_first;

  assign pidx        = addr_q[ADDR_W-1:PAGE_BITS];
  assign ridx        = pidx[IDX_W-1:0];
  assign in_range    = 32'(pidx) < 32'(NUM_PAGES);
  assign aligned     = (addr_q[PAGE_BITS-1:0] == '0);
  assign above_first = 32'(pidx) >= 32'(first_q);

  // Allocator state.
  logic [CNT_W-1:0] free_q, free_d, total_q, total_d;
  logic             ready_q, ready_d, low_w_q, low_w_d, crit_w_q, crit_w_d;
  logic             oom_w_q, oom_w_d;
  logic [IDX_W-1:0] sweep_q, sweep_d;
  logic [ST_W-1:0]  res_st_q, res_st_d;
  logic [ADDR_W-1:0] res_pa_q, res_pa_d;
  logic [RC_W-1:0]  res_rc_q, res_rc_d;
  logic [WARN_W-1:0] res_wn_q, res_wn_d;

  // Memory ports.
  logic             stk_we, ref_we;
  logic [IDX_W-1:0] stk_waddr, stk_wdata, stk_raddr, stk_rdata;
  logic [IDX_W-1:0] ref_waddr;
  logic [RC_W-1:0]  ref_wdata, ref_rdata;

  assign stk_raddr = IDX_W'(free_q - CNT_W'(1));

  rpa_ram #(.Width(IDX_W), .Depth(NUM_PAGES)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  rpa_ram #(.Width(RC_W), .Depth(NUM_PAGES)) u_refs (
    .clk_i   (clk_i),
    .we_i    (ref_we),
    .waddr_i (ref_waddr),
    .wdata_i (ref_wdata),
    .raddr_i (ridx),
    .rdata_o (ref_rdata)
  );

  logic [CNT_W-1:0] newf;
  logic             stack_full;

  assign stack_full = (32'(free_q) >= 32'(NUM_PAGES));

  // Request execution, init sweep and clearing sweep.
  always_comb begin
    free_d    = free_q;
    total_d   = total_q;
    ready_d   = ready_q;
    low_w_d   = low_w_q;
    crit_w_d  = crit_w_q;
    oom_w_d   = oom_w_q;
    sweep_d   = sweep_q;
    res_st_d  = res_st_q;
    res_pa_d  = res_pa_q;
    res_rc_d  = res_rc_q;
    res_wn_d  = res_wn_q;
    stk_we    = 1'b0;
    stk_waddr = free_q[IDX_W-1:0];
    stk_wdata = ridx;
    ref_we    = 1'b0;
    ref_waddr = ridx;
    ref_wdata = '0;
    newf      = free_q;

    if (cmd_i.clr_step || cmd_i.init_step) begin
      ref_we    = 1'b1;
      ref_waddr = sweep_q;
      sweep_d   = sweep_q + IDX_W'(1);
      if (cmd_i.init_step && (32'(sweep_q) >= 32'(first_q))) begin
        stk_we    = 1'b1;
        stk_wdata = sweep_q;
        free_d    = free_q + CNT_W'(1);
        total_d   = total_q + CNT_W'(1);
      end
    end

    if (cmd_i.exec) begin
      res_st_d = ST_OK;
      res_pa_d = '0;
      res_rc_d = '0;
      res_wn_d = WARN_NONE;
      case (req_q)
        REQ_ALLOC: begin
          if (free_q != '0) begin
            newf      = free_q - CNT_W'(1);
            free_d    = newf;
            ref_we    = 1'b1;
            ref_waddr = stk_rdata;
            ref_wdata = RC_W'(1);
            res_pa_d  = ADDR_W'(stk_rdata) << PAGE_BITS;
            if (newf <= crit_wm_q && !crit_w_q) begin
              crit_w_d = 1'b1;
              res_wn_d = WARN_CRIT;
            end else if (newf <= low_wm_q && !low_w_q) begin
              low_w_d  = 1'b1;
              res_wn_d = WARN_LOW;
            end
          end else begin
            res_st_d = ST_OOM;
            if (!oom_w_q) begin
              oom_w_d  = 1'b1;
              res_wn_d = WARN_OOM;
            end
          end
        end
        REQ_FREE: begin
          if (!aligned || !above_first || !in_range) begin
            res_st_d = ST_BADADDR;
          end else if (ready_q && ref_rdata == '0) begin
            res_st_d = ST_DFREE;
          end else if (ref_rdata > RC_W'(1)) begin
            ref_we    = 1'b1;
            ref_wdata = ref_rdata - RC_W'(1);
          end else begin
            ref_we = 1'b1;
            if (!stack_full) begin
              stk_we = 1'b1;
              newf   = free_q + CNT_W'(1);
              free_d = newf;
            end
            if (newf > low_wm_q) low_w_d = 1'b0;
            if (newf > crit_wm_q) crit_w_d = 1'b0;
          end
        end
        REQ_ADDREF: begin
          if (!in_range) begin
            res_st_d = ST_BADADDR;
          end else if (ref_rdata == '0) begin
            res_st_d = ST_UNREF;
          end else if (ref_rdata == RC_MAX) begin
            res_st_d = ST_SAT;
            res_rc_d = RC_MAX;
          end else begin
            ref_we    = 1'b1;
            ref_wdata = ref_rdata + RC_W'(1);
            res_rc_d  = ref_rdata + RC_W'(1);
          end
        end
        REQ_QUERY: begin
          if (!in_range) res_st_d = ST_BADADDR;
          else res_rc_d = ref_rdata;
        end
        REQ_INIT: begin
          free_d   = '0;
          total_d  = '0;
          low_w_d  = 1'b0;
          crit_w_d = 1'b0;
          oom_w_d  = 1'b0;
          ready_d  = 1'b1;
          sweep_d  = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q   <= '0;
      total_q  <= '0;
      ready_q  <= 1'b0;
      low_w_q  <= 1'b0;
      crit_w_q <= 1'b0;
      oom_w_q  <= 1'b0;
      sweep_q  <= '0;
    end else begin
      free_q   <= free_d;
      total_q  <= total_d;
      ready_q  <= ready_d;
      low_w_q  <= low_w_d;
      crit_w_q <= crit_w_d;
      oom_w_q  <= oom_w_d;
      sweep_q  <= sweep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_st_q <= res_st_d;
    res_pa_q <= res_pa_d;
    res_rc_q <= res_rc_d;
    res_wn_q <= res_wn_d;
  end

  // Pressure = used*100/total, restoring division: one bit a cycle unless held.
  logic [CNT_W-1:0]  used;
  logic [MUL_W-1:0]  rem_q, rem_d, dvs;
  logic [PCT_W-1:0]  quot_q, quot_d;
  logic [STEP_W-1:0] step_q, step_d;

  assign used = (free_q >= total_q) ? '0 : (total_q - free_q);
  assign dvs  = MUL_W'(total_q) << step_q;

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    step_d = step_q;
    if (cmd_i.mul_load) begin
      rem_d  = MUL_W'(used) * MUL_W'(PCT_SCALE);
      quot_d = '0;
      step_d = STEP_W'(PCT_W - 1);
    end else if (cmd_i.div_step) begin
      if (rem_q >= dvs) begin
        rem_d          = rem_q - dvs;
        quot_d[step_q] = 1'b1;
      end
      step_d = step_q - STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    step_q <= step_d;
  end

  // Result register toward the output channel.
  logic              out_valid_q;
  logic [ST_W-1:0]   o_st_q;
  logic [ADDR_W-1:0] o_pa_q;
  logic [RC_W-1:0]   o_rc_q;
  logic [WARN_W-1:0] o_wn_q;
  logic [CNT_W-1:0]  o_free_q, o_total_q;
  logic [PCT_W-1:0]  o_pct_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      o_st_q    <= res_st_q;
      o_pa_q    <= res_pa_q;
      o_rc_q    <= res_rc_q;
      o_wn_q    <= res_wn_q;
      o_free_q  <= free_q;
      o_total_q <= total_q;
      o_pct_q   <= (total_q == '0) ? '0 : quot_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = o_st_q;
  assign page_addr_o   = o_pa_q;
  assign ref_count_o   = o_rc_q;
  assign warning_o     = o_wn_q;
  assign free_pages_o  = o_free_q;
  assign total_pages_o = o_total_q;
  assign pressure_o    = o_pct_q;

  assign sts_o.sweep_last = (32'(sweep_q) == 32'(NUM_PAGES - 1));
  assign sts_o.div_last   = (step_q == '0);
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;
  assign sts_o.is_init    = (req_q == REQ_INIT);

endmodule

FILE: design/refcounted_page_allocator.sv
`timescale 1ns / 1ps

// Reference-counted page allocator for 4096 pages of 4096 bytes, with a LIFO
// free stack and a 16-bit count per page, each in its own RAM with one write
// and one registered read port.
// After reset the block runs a clearing pass over all 4096 entries of the
// count memory and accepts no request until it ends. One request is worked
// at a time: a non-init request goes from acceptance to result through a
// read of both memories, a read-modify-write, the multiply by 100, then a
// bit-serial divider for the pressure percentage. The next request can be
// accepted in the cycle after the result is loaded. An init request adds a
// sweep over all pages. A new request is accepted while the previous result
// still waits in the output register.
module refcounted_page_allocator import rpa_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  rpa_in_if.sink               req_i,
  rpa_out_if.source            rsp_o
);

  cmd_t cmd;
  sts_t sts;

  rpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rpa_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .req_type_i    (req_i.req_type),
    .phys_addr_i   (req_i.phys_addr),
    .out_valid_o   (rsp_o.valid),
    .out_ready_i   (rsp_o.ready),
    .status_o      (rsp_o.status),
    .page_addr_o   (rsp_o.page_addr),
    .ref_count_o   (rsp_o.ref_count),
    .warning_o     (rsp_o.warning),
    .free_pages_o  (rsp_o.free_pages_now),
    .total_pages_o (rsp_o.total_pages_now),
    .pressure_o    (rsp_o.pressure_percent)
  );

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import rpa_pkg::*;

  // One request as the sender offers it.
  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [ADDR_W-1:0] addr;
  } page_req_t;

  // One response as the block should return it.
  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [ADDR_W-1:0] page_addr;
    logic [RC_W-1:0]   ref_count;
    logic [WARN_W-1:0] warning;
    logic [CNT_W-1:0]  free_now;
    logic [CNT_W-1:0]  total_now;
    logic [PCT_W-1:0]  pct;
  } page_rsp_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  rpa_in_if  req_if ();
  rpa_out_if rsp_if ();

  refcounted_page_allocator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // Shadow copy of the allocator state and its registers.
  logic [IDX_W-1:0] sh_stack [NUM_PAGES];
  logic [RC_W-1:0]  sh_refs  [NUM_PAGES];
  int unsigned sh_free, sh_total;
  bit sh_ready, sh_low_warned, sh_crit_warned, sh_oom_warned;
  logic [CFG_W-1:0] sh_first, sh_low, sh_crit;

  page_req_t pending_reqs [$];
  page_rsp_t due_rsps [$];
  int  errors;
  int  rsp_seen;
  bit  idle_en;
  bit  hold_rsp;
  int  send_gap, recv_gap;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void shadow_reset();
    sh_first = '0;
    sh_low = 13'd64;
    sh_crit = 13'd16;
    for (int i = 0; i < NUM_PAGES; i++) sh_refs[i] = '0;
    sh_free = 0;
    sh_total = 0;
    sh_ready = 0;
    sh_low_warned = 0;
    sh_crit_warned = 0;
    sh_oom_warned = 0;
  endfunction

  function automatic void shadow_push(int unsigned idx);
    if (sh_free < NUM_PAGES) begin
      sh_stack[sh_free] = idx[IDX_W-1:0];
      sh_free++;
    end
  endfunction

  // Applies one request to the shadow state and returns the response it yields.
  function automatic page_rsp_t page_outcome(page_req_t r);
    page_rsp_t o;
    int unsigned idx, c, used;
    o = '0;
    idx = r.addr >> PAGE_BITS;
    case (r.req)
      REQ_ALLOC: begin
        if (sh_free > 0) begin
          sh_free--;
          idx = sh_stack[sh_free];
          sh_refs[idx] = 1;
          o.page_addr = idx << PAGE_BITS;
          if (sh_free <= sh_crit && !sh_crit_warned) begin
            sh_crit_warned = 1;
            o.warning = WARN_CRIT;
          end else if (sh_free <= sh_low && !sh_low_warned) begin
            sh_low_warned = 1;
            o.warning = WARN_LOW;
          end
        end else begin
          o.status = ST_OOM;
          if (!sh_oom_warned) begin
            sh_oom_warned = 1;
            o.warning = WARN_OOM;
          end
        end
      end
      REQ_FREE: begin
        if (r.addr[PAGE_BITS-1:0] != 0 || idx < sh_first || idx >= NUM_PAGES) begin
          o.status = ST_BADADDR;
        end else if (sh_ready && sh_refs[idx] == 0) begin
          o.status = ST_DFREE;
        end else if (sh_refs[idx] > 1) begin
          sh_refs[idx]--;
        end else begin
          sh_refs[idx] = 0;
          shadow_push(idx);
          if (sh_free > sh_low) sh_low_warned = 0;
          if (sh_free > sh_crit) sh_crit_warned = 0;
        end
      end
      REQ_ADDREF: begin
        if (idx >= NUM_PAGES) begin
          o.status = ST_BADADDR;
        end else begin
          c = sh_refs[idx];
          if (c == 0) begin
            o.status = ST_UNREF;
          end else if (c >= RC_MAX) begin
            o.status = ST_SAT;
            o.ref_count = RC_MAX;
          end else begin
            sh_refs[idx] = c + 1;
            o.ref_count = c + 1;
          end
        end
      end
      REQ_QUERY: begin
        if (idx >= NUM_PAGES) o.status = ST_BADADDR;
        else o.ref_count = sh_refs[idx];
      end
      REQ_INIT: begin
        for (int i = 0; i < NUM_PAGES; i++) sh_refs[i] = '0;
        sh_free = 0;
        sh_total = 0;
        sh_low_warned = 0;
        sh_crit_warned = 0;
        sh_oom_warned = 0;
        for (int unsigned p = sh_first; p < NUM_PAGES; p++) begin
          sh_total++;
          shadow_push(p);
        end
        sh_ready = 1;
      end
      default: ;
    endcase
    used = (sh_free >= sh_total) ? 0 : sh_total - sh_free;
    o.free_now = sh_free;
    o.total_now = sh_total;
    o.pct = (sh_total != 0) ? (used * PCT_SCALE) / sh_total : 0;
    return o;
  endfunction

  // Request driver: bursts of idle cycles, valid held until the beat is taken.
  always @(posedge clk_i) begin
    page_req_t head;
    bit nv;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        head = pending_reqs.pop_front();
        due_rsps.push_back(page_outcome(head));
      end
      if (req_if.valid && !req_if.ready) begin
        nv = 1;
      end else if (send_gap > 0) begin
        send_gap--;
        nv = 0;
      end else if (idle_en && $urandom_range(0, 11) == 0) begin
        send_gap = $urandom_range(0, 17);
        nv = 0;
      end else begin
        nv = pending_reqs.size() > 0;
      end
      req_if.valid <= nv;
      if (nv) begin
        req_if.req_type <= pending_reqs[0].req;
        req_if.phys_addr <= pending_reqs[0].addr;
      end
    end
  end

  // Response monitor: random back-pressure and in-order field checks.
  always @(posedge clk_i) begin
    page_rsp_t want;
    page_rsp_t got;
    bit nr;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = '{rsp_if.status, rsp_if.page_addr, rsp_if.ref_count, rsp_if.warning,
                rsp_if.free_pages_now, rsp_if.total_pages_now, rsp_if.pressure_percent};
        rsp_seen++;
        if (due_rsps.size() == 0) begin
          $display("%0t: unexpected response beat %p", $time, got);
          errors++;
        end else begin
          want = due_rsps.pop_front();
          if (got.status != want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
          end
          if (got.page_addr != want.page_addr) begin
            $display("%0t: page_addr expected %h actual %h", $time, want.page_addr,
                     got.page_addr);
            errors++;
          end
          if (got.ref_count != want.ref_count) begin
            $display("%0t: ref_count expected %0d actual %0d", $time, want.ref_count,
                     got.ref_count);
            errors++;
          end
          if (got.warning != want.warning) begin
            $display("%0t: warning expected %0d actual %0d", $time, want.warning,
                     got.warning);
            errors++;
          end
          if (got.free_now != want.free_now) begin
            $display("%0t: free_pages_now expected %0d actual %0d", $time, want.free_now,
                     got.free_now);
            errors++;
          end
          if (got.total_now != want.total_now) begin
            $display("%0t: total_pages_now expected %0d actual %0d", $time,
                     want.total_now, got.total_now);
            errors++;
          end
          if (got.pct != want.pct) begin
            $display("%0t: pressure_percent expected %0d actual %0d", $time, want.pct,
                     got.pct);
            errors++;
          end
        end
      end
      if (hold_rsp) begin
        nr = 0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        nr = 0;
      end else if (idle_en && $urandom_range(0, 11) == 0) begin
        recv_gap = $urandom_range(0, 17);
        nr = 0;
      end else begin
        nr = 1;
      end
      rsp_if.ready <= nr;
    end
  end

  task automatic queue_req(logic [REQ_W-1:0] r, logic [ADDR_W-1:0] a);
    page_req_t p;
    p.req = r;
    p.addr = a;
    pending_reqs.push_back(p);
  endtask

  // Waits until every queued request has been answered, then lets the block settle.
  task automatic drain();
    while (pending_reqs.size() != 0 || due_rsps.size() != 0 || req_if.valid)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_FIRST: sh_first = val;
      CFG_LOW:   sh_low = val;
      CFG_CRIT:  sh_crit = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Page address that mostly hits pages near the top of the stack.
  function automatic logic [ADDR_W-1:0] pick_addr(int unsigned lo);
    int unsigned base;
    int unsigned roll;
    base = (lo > NUM_PAGES - 64) ? lo : NUM_PAGES - 64;
    if (base >= NUM_PAGES) base = NUM_PAGES - 8;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(base, NUM_PAGES - 1) << PAGE_BITS;
    if (roll < 90) return $urandom_range(0, NUM_PAGES - 1) << PAGE_BITS;
    return $urandom_range(0, 24'hFFFFFF);
  endfunction

  task automatic random_phase(int n, int unsigned lo);
    int unsigned roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 36)      queue_req(REQ_ALLOC, $urandom_range(0, 24'hFFFFFF));
      else if (roll < 68) queue_req(REQ_FREE, pick_addr(lo));
      else if (roll < 84) queue_req(REQ_ADDREF, pick_addr(lo));
      else if (roll < 95) queue_req(REQ_QUERY, pick_addr(lo));
      else if (roll < 97) queue_req(REQ_INIT, $urandom_range(0, 24'hFFFFFF));
      else queue_req(3'($urandom_range(5, 7)), $urandom_range(0, 24'hFFFFFF));
    end
  endtask

  initial begin
    int unsigned firsts [6] = '{4056, 3896, 0, 4096, 4000, 4090};
    int unsigned lows   [6] = '{20, 64, 4096, 0, 48, 3};
    int unsigned crits  [6] = '{8, 16, 0, 4096, 10, 1};
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    req_if.valid = 1'b0;
    req_if.req_type = '0;
    req_if.phys_addr = '0;
    rsp_if.ready = 1'b0;
    errors = 0;
    rsp_seen = 0;
    idle_en = 1;
    hold_rsp = 0;
    send_gap = 0;
    recv_gap = 0;
    shadow_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Before the first init: empty stack, unreferenced pages, unknown codes.
    queue_req(REQ_QUERY, 24'h000000);
    queue_req(REQ_QUERY, 24'hFFFFFF);
    queue_req(REQ_ADDREF, 24'h005000);
    queue_req(REQ_ALLOC, 24'h000000);
    queue_req(REQ_ALLOC, 24'hFFFFFF);
    queue_req(REQ_FREE, 24'h005001);
    queue_req(3'd5, 24'h123456);
    queue_req(3'd6, 24'h000000);
    queue_req(3'd7, 24'hFFFFFF);
    queue_req(REQ_FREE, 24'h005000);
    queue_req(REQ_FREE, 24'h005000);
    queue_req(REQ_ALLOC, 24'h000000);
    queue_req(REQ_ADDREF, 24'h005FFF);
    queue_req(REQ_FREE, 24'h005000);
    queue_req(REQ_QUERY, 24'h005800);
    queue_req(REQ_FREE, 24'hFFF000);
    drain();
    write_reg(CFG_FIRST, 13'd100);
    queue_req(REQ_FREE, 24'h032000);
    queue_req(REQ_FREE, 24'h000000);

    // Push pages with frees before any init, with a few allocs in between.
    for (int i = 0; i < 200; i++) begin
      if ($urandom_range(0, 19) == 0) queue_req(REQ_ALLOC, '0);
      else queue_req(REQ_FREE, $urandom_range(100, NUM_PAGES - 1) << PAGE_BITS);
    end
    drain();

    // Random phases over several register settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_FIRST, CFG_W'(firsts[ph]));
      write_reg(CFG_LOW, CFG_W'(lows[ph]));
      write_reg(CFG_CRIT, CFG_W'(crits[ph]));
      queue_req(REQ_INIT, '0);
      if (firsts[ph] >= NUM_PAGES - 64) begin
        // Drive the stack empty, then past empty, then return pages.
        for (int i = 0; i < NUM_PAGES + 2 - firsts[ph] && i < 70; i++)
          queue_req(REQ_ALLOC, '0);
      end
      random_phase(200, firsts[ph]);
      if (ph == 1) begin
        repeat (30) @(posedge clk_i);
        hold_rsp = 1;
        repeat (400) @(posedge clk_i);
        hold_rsp = 0;
      end
      drain();
    end

    // Last part without idling: raise one page's reference count repeatedly.
    idle_en = 0;
    write_reg(CFG_FIRST, 13'd4000);
    write_reg(CFG_LOW, 13'd0);
    write_reg(CFG_CRIT, 13'd0);
    queue_req(REQ_INIT, '0);
    queue_req(REQ_ALLOC, '0);
    for (int i = 0; i < 100; i++) queue_req(REQ_ADDREF, 24'hFFFABC);
    queue_req(REQ_QUERY, 24'hFFF000);
    queue_req(REQ_FREE, 24'hFFF000);
    queue_req(REQ_QUERY, 24'hFFF000);
    drain();

    $display("Covered %0d responses: pre-init frees, bad addresses, exhaustion,",
             rsp_seen);
    $display("watermark warnings over six register settings and shared page counts.");
    if (errors == 0 && due_rsps.size() == 0) begin
      $display("refcounted_page_allocator verification clean");
    end else begin
      $display("refcounted_page_allocator verification failed");
    end
    $finish;
  end

  // Hard limit on run time.
  initial begin
    #20_000_000;
    $display("refcounted_page_allocator verification failed");
    $finish;
  end

endmodule
